FILE: rtl/double_ended_queue_assert.svh
// Assertion macros for the double-ended queue.
// Included by the top level; holds no logic of its own.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("double_ended_queue: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("double_ended_queue: assertion failed");
`else
`define DEQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define DEQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

FILE: rtl/deq_pkg.sv
// Shared types and constants of the double-ended queue.
// Used by every module of the block; depends on nothing.
package deq_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_OUT_W   = 6;
  localparam int unsigned DEPTH_DEFAULT = 32;

  // Command queue between the front and back parts.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One classified command as it travels through the command queue.
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Control fields of a pending result word.
  typedef struct packed {
    status_e status;
    logic    last;
    logic    use_mem;
  } res_t;

endpackage

FILE: rtl/deq_front.sv
// Front part: accepts input words, drops unknown operation codes and
// forwards the rest as commands. Depends on deq_pkg.
module deq_front import deq_pkg::*; (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  logic                     cmd_ready_i
);

  logic op_known;

  // Classify the operation code; unknown codes are taken and discarded.
  always_comb begin
    op_known = operation_i inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT,
                                   OP_POP_BACK, OP_DUMP};
    cmd_o.op    = op_known ? op_e'(operation_i) : OP_DUMP;
    cmd_o.value = push_value_i;
  end

  // Unknown codes need no room in the command queue.
  assign in_ready_o  = cmd_ready_i || !op_known;
  assign cmd_valid_o = in_valid_i && op_known;

endmodule

FILE: rtl/deq_cmd_queue.sv
// Short command queue that decouples the front part from the back part.
// Depends on deq_pkg.
module deq_cmd_queue import deq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam logic [CMDQ_PTR_W-1:0] LastPtr = CMDQ_PTR_W'(CMDQ_DEPTH - 1);

  cmd_t                  entries_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PTR_W:0]   fill_q, fill_d;
  logic                  do_push, do_pop;

  assign push_ready_o = fill_q != (CMDQ_PTR_W + 1)'(CMDQ_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + CMDQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + CMDQ_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + (CMDQ_PTR_W + 1)'(1);
      2'b01:   fill_d = fill_q - (CMDQ_PTR_W + 1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/deq_back.sv
// Back part: holds the ring store, the front index and the fill count,
// carries out commands and drives the result register. Depends on deq_pkg.
module deq_back import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  cmd_t                     cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] data_value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     last_of_run_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   RingLen  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(DEPTH);

  // Position in the ring a given offset after a base position.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= RingLen) begin
      sum = sum - RingLen;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] dump_idx_q, dump_idx_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  logic [CNT_W-1:0] res_count_q, res_count_d;

  logic             issue, is_full, is_empty, dump_last;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  assign is_full   = count_q == FullCnt;
  assign is_empty  = count_q == '0;
  assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q;
  // A new command may issue whenever the result register is free or drains.
  assign issue     = cmd_valid_i && (!res_valid_q || out_ready_i);

  // Command execution.
  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    res_valid_d = res_valid_q && !out_ready_i;
    res_d       = res_q;
    res_count_d = res_count_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = front_q;
    rd_en       = 1'b0;
    rd_addr     = front_q;
    if (issue) begin
      res_valid_d   = 1'b1;
      res_d.status  = ST_OK;
      res_d.last    = 1'b1;
      res_d.use_mem = 1'b0;
      res_count_d   = count_q;
      cmd_ready_o   = 1'b1;
      case (cmd_i.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (is_full) begin
            res_d.status = ST_FULL;
          end else begin
            wr_en = 1'b1;
            if (cmd_i.op == OP_PUSH_FRONT) begin
              front_d = (front_q == '0) ? LastIdx : front_q - IDX_W'(1);
              wr_addr = front_d;
            end else begin
              wr_addr = ring_pos(front_q, IDX_W'(count_q));
            end
            count_d     = count_q + CNT_W'(1);
            res_count_d = count_d;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (is_empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            rd_en         = 1'b1;
            res_d.use_mem = 1'b1;
            if (cmd_i.op == OP_POP_FRONT) begin
              rd_addr = front_q;
              front_d = ring_pos(front_q, IDX_W'(1));
            end else begin
              rd_addr = ring_pos(front_q, IDX_W'(count_q - CNT_W'(1)));
            end
            count_d     = count_q - CNT_W'(1);
            res_count_d = count_d;
          end
        end
        OP_DUMP: begin
          if (is_empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            // One entry per cycle while the output is not stalled; the command stays queued until the last.
            rd_en         = 1'b1;
            res_d.use_mem = 1'b1;
            rd_addr       = ring_pos(front_q, dump_idx_q);
            res_d.last    = dump_last;
            if (dump_last) begin
              dump_idx_d = '0;
            end else begin
              dump_idx_d  = dump_idx_q + IDX_W'(1);
              cmd_ready_o = 1'b0;
            end
          end
        end
        default: begin
          res_valid_d = res_valid_q && !out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      dump_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload and ring store carry no reset.
  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    res_count_q <= res_count_d;
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o   = res_valid_q;
  assign data_value_o  = res_q.use_mem ? rd_data_q : '0;
  assign status_o      = res_q.status;
  assign last_of_run_o = res_q.last;
  assign entry_count_o = COUNT_OUT_W'(res_count_q);

endmodule

FILE: rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a ring store of DEPTH entries,
// built from deq_front, deq_cmd_queue and deq_back over deq_pkg. Pushes and
// pops at either end sustain one word per cycle unless the output stalls; each
// word passes the command queue and then the result register. A dump
// returns the held entries in turn through the ring store's single read port.
// Unknown operation codes are taken and give no result. A two-entry command
// queue lets input keep flowing while a result waits at the output register.
`include "double_ended_queue_assert.svh"

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] data_value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     last_of_run_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  logic fe_valid, fe_ready, be_valid, be_ready;
  cmd_t fe_cmd, be_cmd;

  // Classification of incoming words.
  deq_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (fe_valid),
    .cmd_o        (fe_cmd),
    .cmd_ready_i  (fe_ready)
  );

  // Decoupling queue.
  deq_cmd_queue u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_cmd_o    (be_cmd)
  );

  // Execution against the ring store.
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (be_valid),
    .cmd_ready_o   (be_ready),
    .cmd_i         (be_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_value_o  (data_value_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o),
    .entry_count_o (entry_count_o)
  );

  // An empty status means nothing is held and no value is returned.
  `DEQ_ASSERT_IMP(a_empty_clean, clk_i, rst_ni,
    out_valid_o && (status_o == ST_EMPTY), (data_value_o == '0) && (entry_count_o == '0))
  // A dropped push only happens with the store full.
  `DEQ_ASSERT_IMP(a_full_count, clk_i, rst_ni,
    out_valid_o && (status_o == ST_FULL),
    (entry_count_o == COUNT_OUT_W'(DEPTH)) && (data_value_o == '0))
  // Any failing status ends its run at once.
  `DEQ_ASSERT_IMP(a_fail_last, clk_i, rst_ni,
    out_valid_o && (status_o != ST_OK), last_of_run_o)
  // A command issued by the back part always yields a result next cycle.
  `DEQ_ASSERT_NXT(a_cmd_result, clk_i, rst_ni, be_valid && be_ready, out_valid_o)

endmodule
